@@ design/cnaf_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// cnaf_pkg
// Shared constants, types and helpers of the four-neighbour mean filter.
// ============================================================================
package cnaf_pkg;

    // default geometry limits and pixel depth
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int DEF_PIXEL_BITS = 8;

    // configuration register widths and reset values
    localparam int CFG_WIDTH_BITS  = 12;
    localparam int CFG_HEIGHT_BITS = 13;
    localparam int RESET_WIDTH     = 1080;
    localparam int RESET_HEIGHT    = 1920;
    localparam int MIN_DIM         = 3;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register indexes (taken from paddr word bit)
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // output queue depth, power of two
    localparam int FIFO_DEPTH = 4;

    // push request towards the output queue
    typedef struct packed {
        logic first;
        logic second;
    } t_push_req;

    // index of the last row or column for a requested size, clamped to MIN_DIM..hi
    function automatic int dim_last(int unsigned v, int hi);
        int r;
        begin
            if (v < MIN_DIM) r = MIN_DIM;
            else if (v > hi) r = hi;
            else r = int'(v);
            return r - 1;
        end
    endfunction

endpackage

@@ design/cnaf_out_fifo.sv @@
`timescale 1ns / 1ps
// ============================================================================
// cnaf_out_fifo
// Small result queue that takes one or two results a cycle and hands out one.
// ============================================================================
module cnaf_out_fifo #(
    parameter int DATA_W = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cnaf_pkg::t_push_req  i_push,
    input  logic [DATA_W-1:0]    i_data0,
    input  logic [DATA_W-1:0]    i_data1,
    output logic                 o_room,
    output logic                 o_valid,
    output logic [DATA_W-1:0]    o_data,
    input  logic                 i_ready
);

    localparam int DEPTH = cnaf_pkg::FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wp, r_rp;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];
    // space for two results even if nothing leaves this cycle
    assign o_room  = (r_count <= CNT_W'(DEPTH - 2));

    assign n_count = r_count + CNT_W'(i_push.first) + CNT_W'(i_push.second)
                     - CNT_W'(pop);

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push.first) r_mem[r_wp] <= i_data0;
        if (i_push.second) r_mem[r_wp + PTR_W'(1)] <= i_data1;
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + PTR_W'(i_push.first) + PTR_W'(i_push.second);
            r_rp    <= r_rp + PTR_W'(pop);
            r_count <= n_count;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("result queue overflow");

    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.second |-> i_push.first)
        else $error("second result pushed without the first");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.second |-> $past(o_room) || o_room)
        else $error("two results pushed into a full queue");
`endif

endmodule

@@ design/cross_neighbour_average_filter_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// cross_neighbour_average_filter_top
// Four-neighbour mean filter over a raster-order pixel stream.
// ============================================================================
// Pixels enter on the s_axis channel in raster order, one per transfer.
// Results leave on m_axis carrying the pixel and its row/column; tlast flags
// the final result of the frame. Output row r-1 is produced while row r
// arrives; a pixel of the last row yields two results (the row above, then
// itself). The first row of a frame yields nothing.
// Throughput: one pixel per cycle while s_axis_tready is high; on the last row
// the single result per cycle on m_axis holds the input back. Each result is
// written into the result queue as the pixel that causes it is accepted.
// The line stores are synchronous memories with one read port each; reads for
// the next pixel are issued while the current one is accepted.
// A register write over the APB port starts a refetch through ST_FILL_MID and
// ST_FILL_NXT during which s_axis_tready is low. Reset clears the counters and
// loads width 1080 and height 1920; line store contents are not cleared.
// When m_axis stalls the four-entry result queue fills and s_axis_tready
// drops; no result is dropped.
// ============================================================================
module cross_neighbour_average_filter_top #(
    parameter int MAX_WIDTH  = cnaf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cnaf_pkg::DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = cnaf_pkg::DEF_PIXEL_BITS,
    localparam int COL_W      = $clog2(MAX_WIDTH),
    localparam int ROW_W      = $clog2(MAX_HEIGHT),
    localparam int IN_TDATA_W = ((PIXEL_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((PIXEL_BITS + ROW_W + COL_W + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input pixel stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [IN_TDATA_W-1:0]             s_axis_tdata,  // pixel_in
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [OUT_TDATA_W-1:0]            m_axis_tdata,  // pixel_out, out_row, out_column
    output logic                              m_axis_tlast,  // frame_end
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cnaf_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [cnaf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [cnaf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int SUM_W = PIXEL_BITS + 2;
    localparam int RES_W = PIXEL_BITS + ROW_W + COL_W + 1;

    typedef enum logic [2:0] {
        ST_RUN      = 3'b001,
        ST_FILL_MID = 3'b010,
        ST_FILL_NXT = 3'b100
    } t_fetch_state;

    // configuration
    logic [cnaf_pkg::CFG_WIDTH_BITS-1:0]  r_frame_width;
    logic [cnaf_pkg::CFG_HEIGHT_BITS-1:0] r_frame_height;
    logic [COL_W-1:0]                     r_w_last;
    logic [ROW_W-1:0]                     r_h_last;
    logic                                 cfg_we;

    // position and window
    logic [COL_W-1:0]      r_col, n_col;
    logic [ROW_W-1:0]      r_row, n_row;
    logic [PIXEL_BITS-1:0] r_left;
    logic [PIXEL_BITS-1:0] r_mid;
    t_fetch_state          r_state, n_state;

    // line stores
    logic [PIXEL_BITS-1:0] r_mid_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_up_mem  [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_mid_q, r_up_q;
    logic                  mid_re, up_re, up_we;
    logic [COL_W-1:0]      mid_raddr, up_raddr;

    // datapath
    logic                  acc, last_col, last_row, border, row_zero;
    logic [COL_W-1:0]      col_n1, col_n2;
    logic [PIXEL_BITS-1:0] pix, val;
    logic [SUM_W-1:0]      sum;
    logic [RES_W-1:0]      res0, res1;
    cnaf_pkg::t_push_req   push;
    logic                  q_room;
    logic [RES_W-1:0]      q_data;

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == cnaf_pkg::REG_FRAME_HEIGHT)
                    ? cnaf_pkg::APB_DATA_W'(r_frame_height)
                    : cnaf_pkg::APB_DATA_W'(r_frame_width);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= cnaf_pkg::CFG_WIDTH_BITS'(cnaf_pkg::RESET_WIDTH);
            r_frame_height <= cnaf_pkg::CFG_HEIGHT_BITS'(cnaf_pkg::RESET_HEIGHT);
            r_w_last <= COL_W'(cnaf_pkg::dim_last(cnaf_pkg::RESET_WIDTH, MAX_WIDTH));
            r_h_last <= ROW_W'(cnaf_pkg::dim_last(cnaf_pkg::RESET_HEIGHT, MAX_HEIGHT));
        end else if (cfg_we) begin
            if (paddr[2] == cnaf_pkg::REG_FRAME_WIDTH) begin
                r_frame_width <= pwdata[cnaf_pkg::CFG_WIDTH_BITS-1:0];
                r_w_last <= COL_W'(cnaf_pkg::dim_last(
                    32'(pwdata[cnaf_pkg::CFG_WIDTH_BITS-1:0]), MAX_WIDTH));
            end else begin
                r_frame_height <= pwdata[cnaf_pkg::CFG_HEIGHT_BITS-1:0];
                r_h_last <= ROW_W'(cnaf_pkg::dim_last(
                    32'(pwdata[cnaf_pkg::CFG_HEIGHT_BITS-1:0]), MAX_HEIGHT));
            end
        end
    end

    // position decode
    assign acc      = s_axis_tvalid && s_axis_tready;
    assign pix      = s_axis_tdata[PIXEL_BITS-1:0];
    assign last_col = (r_col >= r_w_last);
    assign last_row = (r_row >= r_h_last);
    assign row_zero = (r_row == '0);
    assign col_n1   = last_col ? '0 : r_col + COL_W'(1);
    assign col_n2   = (col_n1 >= r_w_last) ? '0 : col_n1 + COL_W'(1);

    // pixel counters
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (acc) begin
            n_col = col_n1;
            if (last_col) n_row = last_row ? '0 : r_row + ROW_W'(1);
        end
    end

    // fetch control: refetch the window after a geometry change
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_RUN:      n_state = ST_RUN;
            ST_FILL_MID: n_state = ST_FILL_NXT;
            ST_FILL_NXT: n_state = ST_RUN;
            default:     n_state = ST_RUN;
        endcase
        if (cfg_we) n_state = ST_FILL_MID;
    end

    assign s_axis_tready = (r_state == ST_RUN) && q_room;

    // read ports: while running, fetch middle two ahead and upper one ahead
    always_comb begin
        mid_re    = 1'b0;
        up_re     = 1'b0;
        mid_raddr = col_n2;
        up_raddr  = col_n1;
        case (r_state)
            ST_RUN: begin
                mid_re = acc;
                up_re  = acc;
            end
            ST_FILL_MID: begin
                mid_re    = 1'b1;
                mid_raddr = r_col;
            end
            ST_FILL_NXT: begin
                mid_re    = 1'b1;
                up_re     = 1'b1;
                mid_raddr = col_n1;
                up_raddr  = r_col;
            end
            default: begin
                mid_re = 1'b0;
                up_re  = 1'b0;
            end
        endcase
    end

    assign up_we = acc && !row_zero;

    // middle line store
    always_ff @(posedge i_clk) begin
        if (acc) r_mid_mem[r_col] <= pix;
        if (mid_re) r_mid_q <= r_mid_mem[mid_raddr];
    end

    // upper line store
    always_ff @(posedge i_clk) begin
        if (up_we) r_up_mem[r_col] <= r_mid;
        if (up_re) r_up_q <= r_up_mem[up_raddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_left  <= '0;
            r_state <= ST_RUN;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_state <= n_state;
            if (up_we) r_left <= r_mid;
        end
    end

    // current middle pixel follows the look-ahead read
    always_ff @(posedge i_clk) begin
        if (acc || (r_state == ST_FILL_NXT)) r_mid <= r_mid_q;
    end

    // mean of up, left, right and the new pixel; border pixels pass the centre through
    assign sum = SUM_W'(r_up_q) + SUM_W'(r_left) + SUM_W'(r_mid_q) + SUM_W'(pix);
    assign border = (r_row == ROW_W'(1)) || (r_col == '0) || last_col;
    assign val = border ? r_mid : sum[SUM_W-1:2];

    assign res0 = {1'b0, r_col, r_row - ROW_W'(1), val};
    assign res1 = {last_col, r_col, r_row, pix};
    assign push.first  = acc && !row_zero;
    assign push.second = acc && !row_zero && last_row;

    cnaf_out_fifo #(
        .DATA_W (RES_W)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data0 (res0),
        .i_data1 (res1),
        .o_room  (q_room),
        .o_valid (m_axis_tvalid),
        .o_data  (q_data),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = OUT_TDATA_W'(q_data[RES_W-2:0]);
    assign m_axis_tlast = q_data[RES_W-1];

`ifndef SYNTH
    a_cfg_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_we |=> !s_axis_tready)
        else $error("pixel accepted during window refetch");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && last_row && last_col) |=> (r_col == '0) && (r_row == '0))
        else $error("counters not cleared at end of frame");

    a_row_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !last_col) |=> (r_row == $past(r_row)))
        else $error("row changed inside a row");
`endif

endmodule
